### hdl/button_led_sequence_fsm_top_assert.svh
// Assertion macros shared by the checker of the LED sequencer.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef BUTTON_LED_SEQUENCE_FSM_TOP_ASSERT_SVH
`define BUTTON_LED_SEQUENCE_FSM_TOP_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define BLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bls_pkg.sv
package bls_pkg;

  localparam int LED_COUNT = 4;
  localparam int NOW_W     = 32;
  localparam int PRESS_W   = 16;
  localparam int STEP_W    = 14;
  localparam int MULT_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef logic [LED_COUNT-1:0] led_mask_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd3;

  // Register values after reset.
  localparam logic [PRESS_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [PRESS_W-1:0] EXIT_PRESS_RST = 16'd2000;
  localparam logic [STEP_W-1:0]  STEP_RST       = 14'd500;
  localparam logic [PRESS_W-1:0] HOLD_RST       = 16'd2000;

  // Blink timing: 1000 ms period, LED0 high past the 500 ms point.
  // The remainder is split as 1000 = 125 * 8; x / 125 uses a reciprocal.
  localparam logic [9:0]  BLINK_HALF   = 10'd500;
  localparam logic [6:0]  BLINK_DIV    = 7'd125;
  localparam int          RECIP_SHIFT  = 36;
  localparam logic [29:0] RECIP_125    = 30'd549755813;

  // Result codes of the mode field.
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_LIGHTING = 3'd1;
  localparam logic [2:0] MODE_LIT      = 3'd2;
  localparam logic [2:0] MODE_BLINKING = 3'd3;
  localparam logic [2:0] MODE_SHUTTING = 3'd4;

  // LED action codes.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_MASK = 2'd1;
  localparam logic [1:0] ACT_LED0 = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_LIGHTING = 5'b00010,
    ST_LIT      = 5'b00100,
    ST_BLINKING = 5'b01000,
    ST_SHUTTING = 5'b10000
  } mode_t;

  typedef struct packed {
    logic             cmd;
    logic [NOW_W-1:0] now_ms;
    logic             button_level;
    logic             button_changed;
  } in_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic [1:0] led_action;
    led_mask_t  led_on_mask;
    led_mask_t  led_off_mask;
    logic       led0_level;
  } out_t;

  // Live configuration, with the step thresholds 1x..4x precomputed.
  typedef struct packed {
    logic [PRESS_W-1:0]                long_press_ms;
    logic [PRESS_W-1:0]                exit_press_ms;
    logic [STEP_W-1:0]                 step_ms;
    logic [PRESS_W-1:0]                hold_ms;
    logic [LED_COUNT-1:0][MULT_W-1:0]  step_mult;
  } cfg_t;

  // Beat leaving the state stage.
  typedef struct packed {
    out_t        res;
    logic        blink;
    logic [28:0] blink_hi;
    logic [2:0]  blink_lo;
  } fsm_beat_t;

  // Beat leaving the reciprocal multiply stage.
  typedef struct packed {
    out_t        res;
    logic        blink;
    logic [21:0] quot;
    logic [8:0]  hi_low;
    logic [2:0]  blink_lo;
  } mul_beat_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      ST_LIGHTING: c = MODE_LIGHTING;
      ST_LIT:      c = MODE_LIT;
      ST_BLINKING: c = MODE_BLINKING;
      ST_SHUTTING: c = MODE_SHUTTING;
      default:     c = MODE_IDLE;
    endcase
    return c;
  endfunction

  // Thresholds at which LED i changes: (i + 1) * step.
  function automatic logic [LED_COUNT-1:0][MULT_W-1:0] step_mults(logic [STEP_W-1:0] s);
    logic [LED_COUNT-1:0][MULT_W-1:0] m;
    for (int i = 0; i < LED_COUNT; i++) begin
      m[i] = MULT_W'(32'(s) * (i + 1));
    end
    return m;
  endfunction

endpackage

### hdl/bls_fsm.sv
module bls_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  bls_pkg::in_t       item,
  input  bls_pkg::cfg_t      cfg,
  output bls_pkg::fsm_beat_t beat_r
);
  import bls_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [NOW_W-1:0] press_start_r, press_start_nxt;
  logic             press_valid_r, press_valid_nxt;
  logic [NOW_W-1:0] entry_r, entry_nxt;
  fsm_beat_t        beat_nxt;
  logic [NOW_W-1:0] elapsed;
  logic [NOW_W-1:0] held;
  led_mask_t        reach;
  led_mask_t        light_on;

  // Step thresholds reached; a zero step reaches them all at once.
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      reach[i]                  = elapsed >= NOW_W'(cfg.step_mult[i]);
      light_on[LED_COUNT-1-i]   = reach[i];
    end
  end

  assign elapsed = item.now_ms - entry_r;
  assign held    = item.now_ms - press_start_r;

  // Mode transitions and the LED commands of one item.
  always_comb begin
    mode_nxt        = mode_r;
    press_start_nxt = press_start_r;
    press_valid_nxt = press_valid_r;
    entry_nxt       = entry_r;
    beat_nxt        = '0;
    beat_nxt.res.led_action = ACT_NONE;
    beat_nxt.blink_hi = elapsed[NOW_W-1:3];
    beat_nxt.blink_lo = elapsed[2:0];
    if (item.cmd) begin
      if (item.button_changed) begin
        if (item.button_level) begin
          press_start_nxt = item.now_ms;
          press_valid_nxt = 1'b1;
        end else begin
          if (press_valid_r) begin
            if (mode_r == ST_IDLE && held >= NOW_W'(cfg.long_press_ms)) begin
              mode_nxt = ST_LIGHTING;
            end else if (mode_r == ST_BLINKING && held >= NOW_W'(cfg.exit_press_ms)) begin
              mode_nxt = ST_SHUTTING;
            end
          end
          press_valid_nxt = 1'b0;
        end
      end
    end else begin
      case (mode_r)
        ST_LIGHTING: begin
          beat_nxt.res.led_action   = ACT_MASK;
          beat_nxt.res.led_on_mask  = light_on;
          beat_nxt.res.led_off_mask = ~light_on;
          if (&light_on) begin
            mode_nxt = ST_LIT;
          end
        end
        ST_LIT: begin
          if (elapsed >= NOW_W'(cfg.hold_ms)) begin
            beat_nxt.res.led_action   = ACT_MASK;
            beat_nxt.res.led_off_mask = '1;
            mode_nxt = ST_BLINKING;
          end
        end
        ST_BLINKING: begin
          beat_nxt.res.led_action = ACT_LED0;
          beat_nxt.blink          = 1'b1;
        end
        ST_SHUTTING: begin
          beat_nxt.res.led_action   = ACT_MASK;
          beat_nxt.res.led_off_mask = reach;
          beat_nxt.res.led_on_mask  = ~reach;
          if (&reach) begin
            mode_nxt = ST_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    if (mode_nxt != mode_r) begin
      entry_nxt = item.now_ms;
    end
    beat_nxt.res.fsm_state = mode_code(mode_nxt);
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ST_IDLE;
      press_start_r <= '0;
      press_valid_r <= 1'b0;
      entry_r       <= '0;
    end else if (ld) begin
      mode_r        <= mode_nxt;
      press_start_r <= press_start_nxt;
      press_valid_r <= press_valid_nxt;
      entry_r       <= entry_nxt;
    end
  end

  // Stage register toward the blink unit.
  always_ff @(posedge clk) begin
    if (ld) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

### hdl/bls_blink.sv
module bls_blink (
  input  logic               clk,
  input  logic               ld_mul,
  input  logic               ld_out,
  input  bls_pkg::fsm_beat_t beat,
  output bls_pkg::out_t      out_r
);
  import bls_pkg::*;

  mul_beat_t   mul_r, mul_nxt;
  out_t        out_nxt;
  logic [58:0] prod;
  logic [8:0]  q125;
  logic [8:0]  rem_raw;
  logic [6:0]  rem;
  logic [9:0]  phase;

  // Quotient of the upper bits by 125; low by at most one.
  always_comb begin
    prod             = 59'(beat.blink_hi) * 59'(RECIP_125);
    mul_nxt.res      = beat.res;
    mul_nxt.blink    = beat.blink;
    mul_nxt.quot     = prod[RECIP_SHIFT+21:RECIP_SHIFT];
    mul_nxt.hi_low   = beat.blink_hi[8:0];
    mul_nxt.blink_lo = beat.blink_lo;
  end

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      mul_r <= mul_nxt;
    end
  end

  // Remainder below 250 fits nine bits; one correction brings it under 125.
  always_comb begin
    q125    = 9'(mul_r.quot[8:0] * BLINK_DIV);
    rem_raw = mul_r.hi_low - q125;
    if (rem_raw >= 9'(BLINK_DIV)) begin
      rem = 7'(rem_raw - 9'(BLINK_DIV));
    end else begin
      rem = rem_raw[6:0];
    end
    phase   = {rem, mul_r.blink_lo};
    out_nxt = mul_r.res;
    out_nxt.led0_level = mul_r.blink && (phase > BLINK_HALF);
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_r <= out_nxt;
    end
  end

endmodule

### hdl/button_led_sequence_fsm_top.sv
// LED sequencer driven by timestamped tick and button beats.
// Input channel: in_valid/in_ready with in_data (cmd, now_ms, button_level,
// button_changed). Output channel: out_valid/out_ready with out_data (mode
// after the beat, LED action, on and off masks, LED0 level). Every input
// beat gives exactly one output beat, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no beat is in flight.
// Throughput is one beat per cycle while the receiver keeps out_ready high.
// An accepted beat passes the input register, state stage, blink multiply
// stage and output register to out_valid. The blink phase (elapsed mod 1000)
// is the deepest path and sets the two stages after the state stage.
// Each stage loads when it is empty or its beat moves on, so a stalled
// receiver holds out_data steady while up to three more beats are taken
// before in_ready drops.
// Synchronous active-low reset empties the pipeline, selects idle, clears
// the pending press and loads the default register values.
module button_led_sequence_fsm_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bls_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bls_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bls_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import bls_pkg::*;

  in_t       in_r;
  cfg_t      cfg_r, cfg_nxt;
  fsm_beat_t fsm_beat;
  logic      v0_r, v1_r, v2_r, v3_r;
  logic      rdy1, rdy2, rdy3;
  logic      ld0, ld1, ld2, ld3, ld4;

  // Stage ready chain and load enables.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;
  assign ld0      = in_valid && in_ready;
  assign ld1      = v0_r && rdy1;
  assign ld2      = v1_r && rdy2;
  assign ld3      = v2_r && rdy3;
  assign ld4      = v3_r && out_ready;

  assign out_valid = v3_r;
  assign cfg_ready = 1'b1;

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= ld0 || (v0_r && !ld1);
      v1_r <= ld1 || (v1_r && !ld2);
      v2_r <= ld2 || (v2_r && !ld3);
      v3_r <= ld3 || (v3_r && !ld4);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (ld0) begin
      in_r <= in_data;
    end
  end

  // Configuration writes; the step thresholds follow the step register.
  always_comb begin
    cfg_nxt = cfg_r;
    case (cfg_index)
      CFG_LONG_PRESS: cfg_nxt.long_press_ms = cfg_data;
      CFG_EXIT_PRESS: cfg_nxt.exit_press_ms = cfg_data;
      CFG_STEP: begin
        cfg_nxt.step_ms   = cfg_data[STEP_W-1:0];
        cfg_nxt.step_mult = step_mults(cfg_data[STEP_W-1:0]);
      end
      CFG_HOLD:       cfg_nxt.hold_ms = cfg_data;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.exit_press_ms <= EXIT_PRESS_RST;
      cfg_r.step_ms       <= STEP_RST;
      cfg_r.hold_ms       <= HOLD_RST;
      cfg_r.step_mult     <= step_mults(STEP_RST);
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_nxt;
    end
  end

  bls_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (ld1),
    .item   (in_r),
    .cfg    (cfg_r),
    .beat_r (fsm_beat)
  );

  bls_blink u_blink (
    .clk    (clk),
    .ld_mul (ld2),
    .ld_out (ld3),
    .beat   (fsm_beat),
    .out_r  (out_data)
  );

endmodule

### hdl/bls_checker.sv
`include "button_led_sequence_fsm_top_assert.svh"

module bls_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input bls_pkg::out_t out_data
);
  import bls_pkg::*;

  logic act_led0;
  logic act_mask;
  logic act_none;
  logic blinking;
  logic overlap;
  logic stray;

  // Result beats sorted by their LED action.
  assign act_led0 = out_valid && (out_data.led_action == ACT_LED0);
  assign act_mask = out_valid && (out_data.led_action == ACT_MASK);
  assign act_none = out_valid && (out_data.led_action == ACT_NONE);
  assign blinking = out_data.fsm_state == MODE_BLINKING;
  assign overlap  = |(out_data.led_on_mask & out_data.led_off_mask);
  assign stray    = |{out_data.led_on_mask, out_data.led_off_mask, out_data.led0_level};

  // The LED0 level is only driven while blinking.
  `BLS_ASSERT_NOW(a_led0_blinking, act_led0, blinking, "LED0 action outside blinking")

  // A mask beat never switches one LED both on and off.
  `BLS_ASSERT_NOW(a_masks_disjoint, act_mask, !overlap, "on and off masks overlap")

  // Unused fields stay zero when no LED changes.
  `BLS_ASSERT_NOW(a_none_quiet, act_none, !stray, "stray LED fields")

  // An empty output stage means the whole pipeline can take a beat.
  `BLS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // A stalled result beat holds.
  `BLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output beat changed")

endmodule

bind button_led_sequence_fsm_top bls_checker u_bls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### bench/led_sequence_check.sv
// Watches the three channels of the LED sequencer, predicts every result beat
// from its own copy of the mode, press and timing registers, and compares.
module led_sequence_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bls_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bls_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bls_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam logic [31:0] BLINK_PERIOD_MS = 32'd1000;
  localparam logic [31:0] BLINK_HIGH_AFTER = 32'd500;

  // Timing registers as last written.
  logic [PRESS_W-1:0] long_press_q;
  logic [PRESS_W-1:0] exit_press_q;
  logic [STEP_W-1:0]  step_q;
  logic [PRESS_W-1:0] hold_q;

  // Sequencer state.
  logic [2:0]       mode_q;
  logic [NOW_W-1:0] press_time_q;
  logic             press_held_q;
  logic [NOW_W-1:0] mode_since_q;

  out_t led_results_due[$];
  int   errors = 0;

  function automatic void switch_mode(logic [2:0] next_mode, logic [NOW_W-1:0] now);
    if (next_mode != mode_q) mode_since_q = now;
    mode_q = next_mode;
  endfunction

  // Whole steps elapsed; a zero step counts as infinitely many.
  function automatic logic [31:0] steps_elapsed(logic [NOW_W-1:0] elapsed);
    if (step_q == '0) return '1;
    return elapsed / 32'(step_q);
  endfunction

  // Applies one input beat to the state and returns the result it produces.
  function automatic out_t predict_led_step(in_t b);
    out_t             r;
    logic [NOW_W-1:0] held;
    logic [NOW_W-1:0] elapsed;
    logic [31:0]      steps;
    r = '0;
    if (b.cmd) begin
      // Button event: presses are timed, releases are judged.
      if (b.button_changed) begin
        if (b.button_level) begin
          press_time_q = b.now_ms;
          press_held_q = 1'b1;
        end else begin
          if (press_held_q) begin
            held = b.now_ms - press_time_q;
            if (mode_q == MODE_IDLE && held >= 32'(long_press_q)) begin
              switch_mode(MODE_LIGHTING, b.now_ms);
            end else if (mode_q == MODE_BLINKING && held >= 32'(exit_press_q)) begin
              switch_mode(MODE_SHUTTING, b.now_ms);
            end
          end
          press_held_q = 1'b0;
        end
      end
    end else begin
      elapsed = b.now_ms - mode_since_q;
      case (mode_q)
        MODE_LIGHTING: begin
          // LEDs come on from the highest index down.
          steps = steps_elapsed(elapsed);
          for (int i = 0; i < LED_COUNT; i++) begin
            if (steps > 32'(i)) r.led_on_mask[LED_COUNT-1-i] = 1'b1;
            else r.led_off_mask[LED_COUNT-1-i] = 1'b1;
          end
          r.led_action = ACT_MASK;
          if (r.led_off_mask == '0) switch_mode(MODE_LIT, b.now_ms);
        end
        MODE_LIT: begin
          if (elapsed >= 32'(hold_q)) begin
            r.led_action   = ACT_MASK;
            r.led_off_mask = '1;
            switch_mode(MODE_BLINKING, b.now_ms);
          end
        end
        MODE_BLINKING: begin
          r.led_action = ACT_LED0;
          r.led0_level = (elapsed % BLINK_PERIOD_MS) > BLINK_HIGH_AFTER;
        end
        MODE_SHUTTING: begin
          // LEDs go off from the lowest index up.
          steps = steps_elapsed(elapsed);
          for (int i = 0; i < LED_COUNT; i++) begin
            if (steps > 32'(i)) r.led_off_mask[i] = 1'b1;
            else r.led_on_mask[i] = 1'b1;
          end
          r.led_action = ACT_MASK;
          if (r.led_on_mask == '0) switch_mode(MODE_IDLE, b.now_ms);
        end
        default: begin
        end
      endcase
    end
    r.fsm_state = mode_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      long_press_q = LONG_PRESS_RST;
      exit_press_q = EXIT_PRESS_RST;
      step_q       = STEP_RST;
      hold_q       = HOLD_RST;
      mode_q       = MODE_IDLE;
      press_time_q = '0;
      press_held_q = 1'b0;
      mode_since_q = '0;
      led_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LONG_PRESS: long_press_q = cfg_data;
          CFG_EXIT_PRESS: exit_press_q = cfg_data;
          CFG_STEP:       step_q       = cfg_data[STEP_W-1:0];
          CFG_HOLD:       hold_q       = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) led_results_due.push_back(predict_led_step(in_data));
      if (out_valid && out_ready) begin
        if (led_results_due.size() == 0) begin
          $error("result beat with no input waiting for it");
          errors++;
        end else begin
          want = led_results_due.pop_front();
          check_field("fsm_state", 32'(want.fsm_state), 32'(out_data.fsm_state));
          check_field("led_action", 32'(want.led_action), 32'(out_data.led_action));
          check_field("led_on_mask", 32'(want.led_on_mask), 32'(out_data.led_on_mask));
          check_field("led_off_mask", 32'(want.led_off_mask), 32'(out_data.led_off_mask));
          check_field("led0_level", 32'(want.led0_level), 32'(out_data.led0_level));
        end
      end
    end
    results_due <= led_results_due.size();
    fail_count  <= errors;
  end

endmodule

### bench/tb_button_led_sequence_fsm_top.sv
// Stimulus and verdict for the LED sequencer; checking lives in led_sequence_check.
module tb_button_led_sequence_fsm_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int DRAIN_CYCLES    = 12;
  localparam int STALL_LIMIT     = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int results_due;

  // Stimulus bookkeeping: the running timestamp and the timing now programmed.
  logic [NOW_W-1:0] clock_ms = '0;
  int unsigned      long_ms = 1000;
  int unsigned      exit_ms = 2000;
  int unsigned      step_len = 500;
  int unsigned      hold_len = 2000;
  int               sent_count = 0;
  int               quiet_left = 0;

  button_led_sequence_fsm_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  led_sequence_check seq_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t make_beat(logic cmd, logic [NOW_W-1:0] t, logic level,
                                    logic changed);
    in_t b;
    b.cmd            = cmd;
    b.now_ms         = t;
    b.button_level   = level;
    b.button_changed = changed;
    return b;
  endfunction

  // Press length near a threshold: sometimes just short, sometimes exact.
  function automatic int unsigned press_len(int unsigned threshold);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2 && threshold > 0) begin
      return threshold - $urandom_range(1, threshold < 50 ? threshold : 50);
    end
    if (r == 2) return threshold;
    return threshold + $urandom_range(0, 300);
  endfunction

  // Receiver pacing: runs of ready broken by stalls of random length.
  initial begin : sink_pacing
    int run_len;
    int stall_len;
    forever begin
      run_len = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Holds one beat until accepted, then maybe idles; valid stays up for a gap of zero.
  task automatic drive_beat(input in_t b);
    int gap;
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) == 0) quiet_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Scenario beat, with an occasional stray beat slipped in ahead of it.
  task automatic post(input in_t b);
    logic [NOW_W-1:0] t;
    if ($urandom_range(0, 99) < 8) begin
      t = ($urandom_range(0, 3) == 0) ? NOW_W'($urandom()) : clock_ms + $urandom_range(0, 100);
      drive_beat(make_beat(1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))));
    end
    drive_beat(b);
  endtask

  task automatic post_tick();
    post(make_beat(CMD_TICK, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  // Ticks that move time forward until at least span has passed.
  task automatic advance_ticks(int unsigned span, int unsigned max_inc);
    int unsigned covered;
    int unsigned inc;
    covered = 0;
    do begin
      inc = $urandom_range(0, max_inc);
      clock_ms += inc;
      covered += inc;
      post_tick();
    end while (covered < span);
  endtask

  // A press and its release, held for about the given threshold.
  task automatic hold_button(int unsigned threshold);
    int unsigned len;
    len = press_len(threshold);
    if ($urandom_range(0, 5) == 0) begin
      post(make_beat(CMD_BUTTON, clock_ms, 1'b1, 1'b1));
      clock_ms += $urandom_range(0, 200);
    end
    post(make_beat(CMD_BUTTON, clock_ms, 1'b1, 1'b1));
    if ($urandom_range(0, 3) == 0) begin
      post(make_beat(CMD_BUTTON, clock_ms + len / 2, 1'b1, 1'b0));
    end
    clock_ms += len;
    post(make_beat(CMD_BUTTON, clock_ms, 1'b0, 1'b1));
  endtask

  // One trip round the modes: light up, hold, blink, long press, shut down.
  task automatic run_cycle();
    if ($urandom_range(0, 7) == 0) clock_ms += $urandom();
    hold_button(long_ms);
    advance_ticks(4 * step_len, step_len + step_len / 2 + 1);
    advance_ticks(hold_len, hold_len / 3 + 1);
    repeat ($urandom_range(2, 8)) begin
      clock_ms += $urandom_range(0, 1500);
      post_tick();
    end
    hold_button(exit_ms);
    advance_ticks(4 * step_len, step_len + step_len / 2 + 1);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Programs all four timing registers in back-to-back beats.
  task automatic write_registers();
    cfg_valid <= 1'b1;
    put_reg(CFG_LONG_PRESS, CFG_DAT_W'(long_ms));
    put_reg(CFG_EXIT_PRESS, CFG_DAT_W'(exit_ms));
    put_reg(CFG_STEP, {2'($urandom_range(0, 3)), STEP_W'(step_len)});
    put_reg(CFG_HOLD, CFG_DAT_W'(hold_len));
    cfg_valid <= 1'b0;
  endtask

  // Stops input and waits until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Timing for each random phase; the first two are the extremes.
  task automatic pick_timing(int phase);
    case (phase)
      0: begin
        long_ms = 0; exit_ms = 0; step_len = 1; hold_len = 0;
      end
      1: begin
        long_ms = 65535; exit_ms = 65535; step_len = 16383; hold_len = 65535;
      end
      2: begin
        // Zero step switches every LED at once.
        long_ms = $urandom_range(0, 2000); exit_ms = $urandom_range(0, 3000);
        step_len = 0; hold_len = $urandom_range(0, 3000);
      end
      default: begin
        long_ms = $urandom_range(0, 3000); exit_ms = $urandom_range(0, 4000);
        step_len = $urandom_range(1, 1500); hold_len = $urandom_range(0, 5000);
      end
    endcase
  endtask

  // Directed walk through every mode with the reset timing.
  task automatic run_directed();
    drive_beat(make_beat(CMD_TICK, 32'd0, 1'b0, 1'b0));
    // Release with no press pending, then a button beat that did not change.
    drive_beat(make_beat(CMD_BUTTON, 32'd5, 1'b0, 1'b1));
    drive_beat(make_beat(CMD_BUTTON, 32'd10, 1'b1, 1'b0));
    // One millisecond short of a long press, across the timestamp wrap.
    drive_beat(make_beat(CMD_BUTTON, 32'hFFFF_FF00, 1'b1, 1'b1));
    drive_beat(make_beat(CMD_BUTTON, 32'hFFFF_FF00 + 32'd999, 1'b0, 1'b1));
    // Exactly a long press, also wrapping: lighting starts at 999.
    drive_beat(make_beat(CMD_BUTTON, 32'hFFFF_FFFF, 1'b1, 1'b1));
    drive_beat(make_beat(CMD_BUTTON, 32'd999, 1'b0, 1'b1));
    drive_beat(make_beat(CMD_TICK, 32'd999, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd1499, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd2998, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd2999, 1'b0, 1'b0));
    // Lit: one short of the hold time, then exactly on it.
    drive_beat(make_beat(CMD_TICK, 32'd4998, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd4999, 1'b0, 1'b0));
    // Blink phase on both sides of the half period and at its end.
    drive_beat(make_beat(CMD_TICK, 32'd5499, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd5500, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd6998, 1'b0, 1'b0));
    // Exit press one short, then exactly long enough.
    drive_beat(make_beat(CMD_BUTTON, 32'd8000, 1'b1, 1'b1));
    drive_beat(make_beat(CMD_BUTTON, 32'd9999, 1'b0, 1'b1));
    drive_beat(make_beat(CMD_BUTTON, 32'd10000, 1'b1, 1'b1));
    drive_beat(make_beat(CMD_BUTTON, 32'd12000, 1'b0, 1'b1));
    // Shutting: all on, half off, then back to idle.
    drive_beat(make_beat(CMD_TICK, 32'd12000, 1'b0, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd13000, 1'b1, 1'b0));
    drive_beat(make_beat(CMD_TICK, 32'd14000, 1'b0, 1'b1));
    // Tick at the top timestamp with both button bits set; they are ignored.
    drive_beat(make_beat(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1));
  endtask

  // Ends the run once nothing has been accepted for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    for (int phase = 0; phase < PHASES; phase++) begin
      pick_timing(phase);
      write_registers();
      phase_start = sent_count;
      while (sent_count - phase_start < ITEMS_PER_PHASE) run_cycle();
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bls_pkg.sv
hdl/bls_fsm.sv
hdl/bls_blink.sv
hdl/button_led_sequence_fsm_top.sv
hdl/bls_checker.sv
bench/led_sequence_check.sv
bench/tb_button_led_sequence_fsm_top.sv
